FILE: hdl/bsp3d_pkg.sv
package bsp3d_pkg;

	// Fixed field widths
	localparam int CFG_W = 6;
	localparam int VAL_W = 4;
	localparam int SUM_W = 19;
	localparam int IDX_W = 2;

	// Size register value after reset
	localparam logic [CFG_W-1:0] SIZE_RESET = 6'd32;

	// Word actions
	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	// Configuration register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_SIZE_X = 2'd0,
		REG_SIZE_Y = 2'd1,
		REG_SIZE_Z = 2'd2
	} cfg_reg_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_READ  = 3'b010,
		ST_DRAIN = 3'b100
	} seq_state_t;

endpackage

FILE: hdl/box_sum_3d_prefix_table.sv
// Three-dimensional summed-volume table. Load words (action 0) fill the grid in
// raster order, x outermost and z innermost, and store the inclusive prefix sum
// of each cell; query words (action 1) return the sum over the box spanned by
// two corners, one result word per query, none per load. A word is accepted
// and its coordinates ordered, the eight corner terms are read from the
// single-port prefix memory (one term a cycle, registered read data), and a
// final step folds in the last term and either writes the new prefix sum back
// or loads the output register. A query waits in that final step while an
// earlier result is still held on a stalled output. The memory has no reset
// and no clearing pass: query only cells that have been loaded.
module box_sum_3d_prefix_table
	import bsp3d_pkg::*;
#(
	parameter int MAX_DIM   = 32,
	parameter int VALUE_MAX = 9
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [IDX_W-1:0]     cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	// input words
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 action,
	input  logic [VAL_W-1:0]     cell_value,
	input  logic [CFG_W-1:0]     corner_a_x,
	input  logic [CFG_W-1:0]     corner_a_y,
	input  logic [CFG_W-1:0]     corner_a_z,
	input  logic [CFG_W-1:0]     corner_b_x,
	input  logic [CFG_W-1:0]     corner_b_y,
	input  logic [CFG_W-1:0]     corner_b_z,
	// result words
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [SUM_W-1:0]     box_sum
);

	localparam int CRD_W = $clog2(MAX_DIM + 1);
	localparam int IW    = $clog2(MAX_DIM);
	localparam int AW    = 3 * IW;
	localparam int DEPTH = 1 << AW;
	localparam int CMP_W = (CRD_W > CFG_W) ? CRD_W : CFG_W;

	// Effective extent of a size register: at least 1, at most MAX_DIM
	function automatic logic [CRD_W-1:0] eff_size(input logic [CFG_W-1:0] s);
		logic [CMP_W-1:0] sw;
		sw = CMP_W'(s);
		if (sw == '0)
			return CRD_W'(1);
		else if (sw > CMP_W'(MAX_DIM))
			return CRD_W'(MAX_DIM);
		else
			return CRD_W'(sw);
	endfunction

	// Clamp a one-based query coordinate into 1..lim
	function automatic logic [CRD_W-1:0] clamp_crd(input logic [CFG_W-1:0] c,
			input logic [CRD_W-1:0] lim);
		logic [CMP_W-1:0] cw;
		logic [CMP_W-1:0] lw;
		cw = CMP_W'(c);
		lw = CMP_W'(lim);
		if (cw == '0)
			return CRD_W'(1);
		else if (cw > lw)
			return lim;
		else
			return CRD_W'(cw);
	endfunction

	// Configuration registers
	logic [CFG_W-1:0] size_x_q, size_y_q, size_z_q;

	// Sequencer and latched word
	seq_state_t       state_q;
	logic [2:0]       k_q;
	logic             action_q;
	logic [VAL_W-1:0] cell_q;
	logic [CRD_W-1:0] hi_x_q, hi_y_q, hi_z_q;
	logic [CRD_W-1:0] lo_x_q, lo_y_q, lo_z_q;

	// Load cursor
	logic [CRD_W-1:0] cur_x_q, cur_y_q, cur_z_q;

	// Read-side term pipeline
	logic             term_v_s1, term_neg_s1, term_zero_s1, term_self_s1;
	logic [SUM_W-1:0] rdata_s1;
	logic [SUM_W-1:0] acc_q;

	// Output register
	logic             out_valid_q;
	logic [SUM_W-1:0] box_sum_q;

	// Memory
	logic [SUM_W-1:0] mem [0:DEPTH-1];
	logic             mem_re, mem_we;
	logic [AW-1:0]    mem_addr, rd_addr, wr_addr;
	logic [SUM_W-1:0] mem_wdata;

	logic accept, finish;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign box_sum   = box_sum_q;

	// Take configuration writes; unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= SIZE_RESET;
			size_y_q <= SIZE_RESET;
			size_z_q <= SIZE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SIZE_X: size_x_q <= cfg_data;
				REG_SIZE_Y: size_y_q <= cfg_data;
				REG_SIZE_Z: size_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Effective sizes, clamped and ordered query corners
	logic [CRD_W-1:0] sx, sy, sz;
	logic [CRD_W-1:0] ax, ay, az, bx, by, bz;
	logic [CRD_W-1:0] mnx, mny, mnz, mxx, mxy, mxz;
	logic [VAL_W-1:0] cell_sat;

	always_comb begin
		sx  = eff_size(size_x_q);
		sy  = eff_size(size_y_q);
		sz  = eff_size(size_z_q);
		ax  = clamp_crd(corner_a_x, sx);
		ay  = clamp_crd(corner_a_y, sy);
		az  = clamp_crd(corner_a_z, sz);
		bx  = clamp_crd(corner_b_x, sx);
		by  = clamp_crd(corner_b_y, sy);
		bz  = clamp_crd(corner_b_z, sz);
		mnx = (ax > bx) ? bx : ax;
		mxx = (ax > bx) ? ax : bx;
		mny = (ay > by) ? by : ay;
		mxy = (ay > by) ? ay : by;
		mnz = (az > bz) ? bz : az;
		mxz = (az > bz) ? az : bz;
		if ({4'd0, cell_value} > 8'(VALUE_MAX))
			cell_sat = VAL_W'(VALUE_MAX);
		else
			cell_sat = cell_value;
	end

	// Latch the word: upper and lower corners of the eight terms
	always_ff @(posedge clk) begin
		if (accept) begin
			action_q <= action;
			cell_q   <= cell_sat;
			if (action == ACT_QUERY) begin
				hi_x_q <= mxx;
				hi_y_q <= mxy;
				hi_z_q <= mxz;
				lo_x_q <= mnx - CRD_W'(1);
				lo_y_q <= mny - CRD_W'(1);
				lo_z_q <= mnz - CRD_W'(1);
			end else begin
				hi_x_q <= cur_x_q;
				hi_y_q <= cur_y_q;
				hi_z_q <= cur_z_q;
				lo_x_q <= cur_x_q - CRD_W'(1);
				lo_y_q <= cur_y_q - CRD_W'(1);
				lo_z_q <= cur_z_q - CRD_W'(1);
			end
		end
	end

	// Term k: bit 2/1/0 picks the lower corner on x/y/z
	logic [CRD_W-1:0] tx, ty, tz, tx_m1, ty_m1, tz_m1;
	logic             t_zero, t_self, t_neg;

	always_comb begin
		tx      = k_q[2] ? lo_x_q : hi_x_q;
		ty      = k_q[1] ? lo_y_q : hi_y_q;
		tz      = k_q[0] ? lo_z_q : hi_z_q;
		tx_m1   = tx - CRD_W'(1);
		ty_m1   = ty - CRD_W'(1);
		tz_m1   = tz - CRD_W'(1);
		t_zero  = (tx == '0) || (ty == '0) || (tz == '0);
		t_self  = (action_q == ACT_LOAD) && (k_q == '0);
		// query: odd count of lower corners subtracts; load: even count does
		t_neg   = (action_q == ACT_QUERY) ? (^k_q) : (!(^k_q) && (k_q != '0));
		rd_addr = {tx_m1[IW-1:0], ty_m1[IW-1:0], tz_m1[IW-1:0]};
	end

	// Fold the term returned by the memory into the running sum
	logic [SUM_W-1:0] term, acc_next;

	always_comb begin
		if (term_self_s1)
			term = SUM_W'(cell_q);
		else if (term_zero_s1)
			term = '0;
		else
			term = rdata_s1;
		acc_next = term_neg_s1 ? (acc_q - term) : (acc_q + term);
	end

	// Finish a query only when the output register is free
	assign finish = (state_q == ST_DRAIN)
		&& ((action_q == ACT_LOAD) || !out_valid_q || !out_stall);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			k_q       <= '0;
			term_v_s1 <= 1'b0;
		end else begin
			term_v_s1 <= (state_q == ST_READ);
			unique case (state_q)
				ST_IDLE: begin
					if (accept)
						state_q <= ST_READ;
				end
				ST_READ: begin
					k_q <= k_q + 3'd1;
					if (k_q == 3'd7)
						state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (finish)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Term flags and accumulator
	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			term_neg_s1  <= t_neg;
			term_zero_s1 <= t_zero;
			term_self_s1 <= t_self;
		end
		if (accept)
			acc_q <= '0;
		else if (state_q == ST_READ && term_v_s1)
			acc_q <= acc_next;
	end

	// Advance the load cursor with carry into outer axes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q <= CRD_W'(1);
			cur_y_q <= CRD_W'(1);
			cur_z_q <= CRD_W'(1);
		end else if (finish && (action_q == ACT_LOAD)) begin
			if (cur_z_q >= sz) begin
				cur_z_q <= CRD_W'(1);
				if (cur_y_q >= sy) begin
					cur_y_q <= CRD_W'(1);
					if (cur_x_q >= sx)
						cur_x_q <= CRD_W'(1);
					else
						cur_x_q <= cur_x_q + CRD_W'(1);
				end else begin
					cur_y_q <= cur_y_q + CRD_W'(1);
				end
			end else begin
				cur_z_q <= cur_z_q + CRD_W'(1);
			end
		end
	end

	// Result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish && (action_q == ACT_QUERY)) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish && (action_q == ACT_QUERY))
			box_sum_q <= acc_next;
	end

	// Single-port prefix memory: reads during READ, write-back at the end of a load
	always_comb begin
		wr_addr   = {hi_x_q[IW-1:0] - IW'(1), hi_y_q[IW-1:0] - IW'(1),
			hi_z_q[IW-1:0] - IW'(1)};
		mem_re    = (state_q == ST_READ) && !t_zero && !t_self;
		mem_we    = finish && (action_q == ACT_LOAD);
		mem_wdata = acc_next;
		mem_addr  = mem_we ? wr_addr : rd_addr;
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_addr] <= mem_wdata;
		if (mem_re)
			rdata_s1 <= mem[mem_addr];
	end

`ifndef NO_ASSERTIONS
	// A result appears only out of the final step of a query
	a_result_from_drain: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DRAIN) && $past(action_q == ACT_QUERY))
		else $error("result word without a finished query");

	// The single port never reads and writes in one cycle
	a_one_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_re && mem_we))
		else $error("memory read and write collide");

	// The term counter rests at zero outside the read phase
	a_term_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_READ) |-> (k_q == 3'd0))
		else $error("term counter out of step");

	// A held result is not overwritten by the next query
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> $stable(box_sum_q))
		else $error("held result overwritten");
`endif

endmodule
